// ----- hw/rtl/pngunf_pkg.sv -----
// shared types, constants and the paeth predictor for the png scanline unfilter
// no dependencies
`default_nettype none

package pngunf_pkg;

    localparam int unsigned MAX_ROW_BYTES_DEF   = 8192;
    localparam int unsigned MAX_PIXEL_BYTES_DEF = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [1:0] CFG_ROW_BYTES       = 2'd1;
    localparam logic [1:0] CFG_IMAGE_ROWS      = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } t_result;

    // paeth predictor, ties go to a, then b, then c
    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] ta;
        logic signed [10:0] tb;
        logic signed [10:0] tc;
        logic [10:0]        da;
        logic [10:0]        db;
        logic [10:0]        dc;
        logic [7:0]         res;
        sa = signed'({3'b000, a});
        sb = signed'({3'b000, b});
        sc = signed'({3'b000, c});
        ta = sb - sc;
        tb = sa - sc;
        tc = sa + sb - sc - sc;
        da = (ta < 0) ? 11'(-ta) : 11'(ta);
        db = (tb < 0) ? 11'(-tb) : 11'(tb);
        dc = (tc < 0) ? 11'(-tc) : 11'(tc);
        if (da <= db && da <= dc) begin
            res = a;
        end else if (db <= dc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pngunf_line_buf.sv -----
// previous-row line buffer: one write port, one registered read port
// same-address write and read in one cycle forwards the written byte
`default_nettype none

module pngunf_line_buf #(
    parameter int unsigned DEPTH  = 8192,
    parameter int unsigned ADDR_W = 13
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] r_fwd_data;
    logic       r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data  <= r_mem[i_rd_addr];
        r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

// ----- hw/rtl/pngunf_out_buf.sv -----
// output register with a one-entry skid stage
// depends on pngunf_pkg for the result struct
`default_nettype none

module pngunf_out_buf
    import pngunf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            // a push only arrives while the skid stage is empty
            if (i_push) begin
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/png_scanline_unfilter_unit.sv -----
// png scanline unfilter: undoes none, sub, up, average and paeth per row
// results: each data byte transfer gives a registered result; filter bytes give none
// throughput: one byte per cycle while o_in_stall is low, set by the line buffer read issued one column ahead
// reset: synchronous active low; configuration registers return to 1, the next byte is a filter byte
// the line buffer gets no clearing pass, the first row never reads it
// depends on pngunf_pkg, pngunf_line_buf, pngunf_out_buf
`default_nettype none

module png_scanline_unfilter_unit
    import pngunf_pkg::*;
#(
    parameter int unsigned MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
    parameter int unsigned MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // inflated byte stream
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_stream_byte,
    // reconstructed bytes
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_pixel_byte,
    output logic                       o_row_end,
    output logic                       o_image_end,
    output logic                       o_bad_filter
);

    localparam int unsigned COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int unsigned RB_W   = $clog2(MAX_ROW_BYTES) + 2;
    localparam int unsigned HIST_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // configuration registers
    logic [3:0]  r_bpp;
    logic [13:0] r_row_bytes;
    logic [15:0] r_image_rows;

    // row state
    t_filter          r_filter;
    t_filter          n_filter;
    logic             r_bad;
    logic             n_bad;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [15:0]      r_row;
    logic [15:0]      n_row;
    logic             r_await;
    logic             n_await;

    // recent left bytes and upper-left bytes of this row
    logic [7:0] r_left   [MAX_PIXEL_BYTES];
    logic [7:0] r_upleft [MAX_PIXEL_BYTES];

    logic             in_xfer;
    logic             data_xfer;
    logic [3:0]       bpp_eff;
    logic [3:0]       bpp_m1;
    logic [HIST_W-1:0] tap;
    logic [RB_W-1:0]  rb_eff;
    logic [16:0]      rows_eff;
    logic             last_col;
    logic             last_img;
    logic [7:0]       rd_data;
    logic [7:0]       a_byte;
    logic [7:0]       b_byte;
    logic [7:0]       c_byte;
    logic [8:0]       ab_sum;
    logic [7:0]       pred;
    logic [7:0]       val;
    logic             dec_bad;
    t_filter          dec_filter;
    t_result          res;
    t_result          out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp        <= 4'd1;
            r_row_bytes  <= 14'd1;
            r_image_rows <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BYTES_PER_PIXEL: r_bpp        <= i_cfg_data[3:0];
                CFG_ROW_BYTES:       r_row_bytes  <= i_cfg_data[13:0];
                CFG_IMAGE_ROWS:      r_image_rows <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // out-of-range register values are clamped
    always_comb begin
        if (r_bpp == 4'd0) begin
            bpp_eff = 4'd1;
        end else if (32'(r_bpp) > MAX_PIXEL_BYTES) begin
            bpp_eff = 4'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = r_bpp;
        end
        if (r_row_bytes == 14'd0) begin
            rb_eff = RB_W'(1);
        end else if (32'(r_row_bytes) > MAX_ROW_BYTES) begin
            rb_eff = RB_W'(MAX_ROW_BYTES);
        end else begin
            rb_eff = RB_W'(r_row_bytes);
        end
        rows_eff = (r_image_rows == 16'd0) ? 17'd1 : {1'b0, r_image_rows};
    end

    assign bpp_m1 = bpp_eff - 4'd1;
    assign tap    = HIST_W'(bpp_m1);

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign data_xfer = in_xfer && !r_await;

    // neighbours: left, above (zero on the first row) and upper-left
    assign a_byte = r_left[tap];
    assign c_byte = r_upleft[tap];
    assign b_byte = (r_row != 16'd0) ? rd_data : 8'd0;
    assign ab_sum = {1'b0, a_byte} + {1'b0, b_byte};

    always_comb begin
        unique case (r_filter)
            FLT_SUB:   pred = a_byte;
            FLT_UP:    pred = b_byte;
            FLT_AVG:   pred = ab_sum[8:1];
            FLT_PAETH: pred = paeth_pred(a_byte, b_byte, c_byte);
            default:   pred = 8'd0;
        endcase
    end

    assign val      = i_stream_byte + pred;
    assign last_col = (RB_W'(r_col) + RB_W'(1)) >= rb_eff;
    assign last_img = last_col && (({1'b0, r_row} + 17'd1) >= rows_eff);

    // filter byte decode; first row has no row above
    always_comb begin
        dec_bad    = i_stream_byte > 8'(FLT_PAETH);
        dec_filter = dec_bad ? FLT_NONE : t_filter'(i_stream_byte[2:0]);
        if (r_row == 16'd0 && dec_filter == FLT_UP) begin
            dec_filter = FLT_NONE;
        end else if (r_row == 16'd0 && dec_filter == FLT_PAETH) begin
            dec_filter = FLT_SUB;
        end
    end

    always_comb begin
        n_filter = r_filter;
        n_bad    = r_bad;
        n_col    = r_col;
        n_row    = r_row;
        n_await  = r_await;
        if (in_xfer && r_await) begin
            n_filter = dec_filter;
            n_bad    = dec_bad;
            n_col    = '0;
            n_await  = 1'b0;
        end else if (data_xfer) begin
            if (last_col) begin
                n_col   = '0;
                n_await = 1'b1;
                n_row   = last_img ? 16'd0 : r_row + 16'd1;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= FLT_NONE;
            r_bad    <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_await  <= 1'b1;
        end else begin
            r_filter <= n_filter;
            r_bad    <= n_bad;
            r_col    <= n_col;
            r_row    <= n_row;
            r_await  <= n_await;
        end
    end

    // histories clear on each filter byte and shift on each data byte
    always_ff @(posedge i_clk) begin
        if (in_xfer && r_await) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= 8'd0;
                r_upleft[i] <= 8'd0;
            end
        end else if (data_xfer) begin
            r_left[0]   <= val;
            r_upleft[0] <= b_byte;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= r_left[i-1];
                r_upleft[i] <= r_upleft[i-1];
            end
        end
    end

    // line buffer read tracks the next column so the above byte is ready in time
    pngunf_line_buf #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (data_xfer),
        .i_wr_addr (r_col),
        .i_wr_data (val),
        .i_rd_addr (n_col),
        .o_rd_data (rd_data)
    );

    assign res.pixel_byte = val;
    assign res.row_end    = last_col;
    assign res.image_end  = last_img;
    assign res.bad_filter = r_bad;

    pngunf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (data_xfer),
        .i_data  (res),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_pixel_byte = out_data.pixel_byte;
    assign o_row_end    = out_data.row_end;
    assign o_image_end  = out_data.image_end;
    assign o_bad_filter = out_data.bad_filter;

    // skid stage only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid stage full while output register empty");

    // a filter byte transfer starts a row at column zero
    a_filter_starts_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_await) |=> (!r_await && r_col == '0))
        else $error("filter byte did not start a row");

    // the last byte of a row waits for the next filter byte
    a_row_end_awaits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (data_xfer && last_col) |=> (r_await && r_col == '0))
        else $error("row end did not return to filter byte");

    a_image_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_image_end) |-> o_row_end)
        else $error("image end without row end");

endmodule

`default_nettype wire

// ----- dv/tb_png_scanline_unfilter_unit.sv -----
// self-checking testbench for png_scanline_unfilter_unit: directed and random byte streams
// with a built-in unfilter predictor; depends on pngunf_pkg and the unit's rtl
module tb_png_scanline_unfilter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pngunf_pkg::*;

    // extra wait kept after the last expected result when draining
    localparam int          DRAIN_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int          RANDOM_ITEMS   = 1350;
    localparam int          HIST_DEPTH     = MAX_PIXEL_BYTES_DEF;
    localparam int          BAD_FILTER_MIN = FLT_PAETH + 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_stream_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [7:0]            o_pixel_byte;
    logic                  o_row_end;
    logic                  o_image_end;
    logic                  o_bad_filter;

    png_scanline_unfilter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_stream_byte (i_stream_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_byte  (o_pixel_byte),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end),
        .o_bad_filter  (o_bad_filter)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: register shadows plus the unfilter's own history
    // ------------------------------------------------------------------
    logic [3:0]  cfg_bpp;
    logic [13:0] cfg_row_bytes;
    logic [15:0] cfg_image_rows;

    logic [7:0]  line_above [MAX_ROW_BYTES_DEF];
    logic [7:0]  left_bytes [HIST_DEPTH];
    logic [7:0]  upleft_bytes [HIST_DEPTH];
    t_filter     cur_filter;
    logic        cur_bad;
    int unsigned col_pos;
    int unsigned row_pos;
    logic        want_filter;

    t_result     expected_pixels [$];

    int          mismatches = 0;
    int          items_sent = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b1;
    int          out_hold_cycles = 0;
    logic [7:0]  prev_data = 8'h00;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic clear_unfilter_state();
        cfg_bpp        = 4'd1;
        cfg_row_bytes  = 14'd1;
        cfg_image_rows = 16'd1;
        foreach (line_above[i]) line_above[i] = 8'h00;
        foreach (left_bytes[i]) begin
            left_bytes[i]   = 8'h00;
            upleft_bytes[i] = 8'h00;
        end
        cur_filter  = FLT_NONE;
        cur_bad     = 1'b0;
        col_pos     = 0;
        row_pos     = 0;
        want_filter = 1'b1;
    endtask

    function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        int ia;
        int ib;
        int ic;
        int dist_a;
        int dist_b;
        int dist_c;
        ia = a;
        ib = b;
        ic = c;
        // distances of the estimate a + b - c to each neighbour
        dist_a = (ib > ic) ? ib - ic : ic - ib;
        dist_b = (ia > ic) ? ia - ic : ic - ia;
        dist_c = (ia + ib > 2 * ic) ? ia + ib - 2 * ic : 2 * ic - ia - ib;
        if (dist_a <= dist_b && dist_a <= dist_c) begin
            return a;
        end else if (dist_b <= dist_c) begin
            return b;
        end
        return c;
    endfunction

    task automatic unfilter_byte(input logic [7:0] sb);
        int unsigned bpp_eff;
        int unsigned rb_eff;
        int unsigned rows_eff;
        int unsigned col;
        logic [7:0]  a_v;
        logic [7:0]  b_v;
        logic [7:0]  c_v;
        logic [7:0]  pred;
        logic [7:0]  recon;
        t_filter     flt;
        t_result     res;
        bpp_eff  = (cfg_bpp == 0) ? 1 :
                   ((cfg_bpp > MAX_PIXEL_BYTES_DEF) ? MAX_PIXEL_BYTES_DEF : cfg_bpp);
        rb_eff   = (cfg_row_bytes == 0) ? 1 :
                   ((cfg_row_bytes > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : cfg_row_bytes);
        rows_eff = (cfg_image_rows == 0) ? 1 : cfg_image_rows;
        if (want_filter) begin
            // filter byte: no result, sets up the row
            cur_bad = (sb > FLT_PAETH);
            flt     = cur_bad ? FLT_NONE : t_filter'(sb[2:0]);
            if (row_pos == 0 && flt == FLT_UP) flt = FLT_NONE;
            if (row_pos == 0 && flt == FLT_PAETH) flt = FLT_SUB;
            cur_filter = flt;
            foreach (left_bytes[i]) begin
                left_bytes[i]   = 8'h00;
                upleft_bytes[i] = 8'h00;
            end
            col_pos     = 0;
            want_filter = 1'b0;
        end else begin
            col = (col_pos >= MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF - 1 : col_pos;
            a_v = left_bytes[bpp_eff-1];
            b_v = (row_pos != 0) ? line_above[col] : 8'h00;
            c_v = upleft_bytes[bpp_eff-1];
            case (cur_filter)
                FLT_SUB:   pred = a_v;
                FLT_UP:    pred = b_v;
                FLT_AVG:   pred = 8'((int'(a_v) + int'(b_v)) >> 1);
                FLT_PAETH: pred = paeth_choice(a_v, b_v, c_v);
                default:   pred = 8'h00;
            endcase
            recon = sb + pred;
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                left_bytes[i]   = left_bytes[i-1];
                upleft_bytes[i] = upleft_bytes[i-1];
            end
            left_bytes[0]   = recon;
            upleft_bytes[0] = b_v;
            line_above[col] = recon;

            res.pixel_byte = recon;
            res.row_end    = (col + 1 >= rb_eff);
            res.image_end  = 1'b0;
            res.bad_filter = cur_bad;
            if (res.row_end) begin
                want_filter = 1'b1;
                col_pos     = 0;
                if (row_pos + 1 >= rows_eff) begin
                    res.image_end = 1'b1;
                    row_pos       = 0;
                end else begin
                    row_pos = row_pos + 1;
                end
            end else begin
                col_pos = col + 1;
            end
            expected_pixels.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // mostly short idles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0:       prev_data = 8'h00;
            1:       prev_data = 8'hFF;
            2:       prev_data = prev_data;  // runs of equal bytes give paeth ties
            default: prev_data = 8'($urandom);
        endcase
        return prev_data;
    endfunction

    function automatic logic [7:0] pick_filter();
        if ($urandom_range(0, 6) == 0) return 8'($urandom_range(BAD_FILTER_MIN, 255));
        return 8'($urandom_range(FLT_NONE, FLT_PAETH));
    endfunction

    // valid stays high between back-to-back transfers, it only drops ahead of a gap
    task automatic send_byte(input logic [7:0] sb);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= sb;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        unfilter_byte(sb);
        items_sent++;
    endtask

    // filter byte, then data until the row closes
    task automatic send_row(input logic [7:0] flt);
        send_byte(flt);
        do begin
            send_byte(pick_data());
        end while (!want_filter);
    endtask

    // all results in, then a further wait in case the last transfer was a filter byte
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BYTES_PER_PIXEL: cfg_bpp        = val[3:0];
            CFG_ROW_BYTES:       cfg_row_bytes  = val[13:0];
            CFG_IMAGE_ROWS:      cfg_image_rows = val[15:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] bpp,
                                input logic [CFG_DATA_W-1:0] rb,
                                input logic [CFG_DATA_W-1:0] rows);
        wait_drained();
        write_reg(CFG_BYTES_PER_PIXEL, bpp);
        write_reg(CFG_ROW_BYTES, rb);
        write_reg(CFG_IMAGE_ROWS, rows);
        end_writes();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values: one-byte rows, one-row images, so every row is a first row
    task automatic test_defaults_after_reset();
        logic [7:0] flts [7];
        flts = '{FLT_NONE, FLT_SUB, FLT_UP, FLT_AVG, FLT_PAETH, BAD_FILTER_MIN, 8'hFF};
        foreach (flts[i]) begin
            send_byte(flts[i]);
            send_byte(i[0] ? 8'h00 : 8'hFF);
        end
    endtask

    // first row up falls back to none, then each filter and a bad one over the rows above
    task automatic test_every_filter();
        set_geometry(16'd2, 16'd3, 16'd7);
        send_row(FLT_UP);
        send_row(FLT_SUB);
        send_row(FLT_UP);
        send_row(FLT_AVG);
        send_row(FLT_PAETH);
        send_row(8'h80);
        send_row(FLT_NONE);
    endtask

    // registers changed part way through a row and part way through an image
    task automatic test_mid_stream_writes();
        set_geometry(16'd1, 16'd12, 16'hFFFF);
        send_byte(FLT_SUB);
        // new pixel distance straight after the filter byte
        wait_drained();
        write_reg(CFG_BYTES_PER_PIXEL, 16'd4);
        end_writes();
        repeat (5) send_byte(pick_data());
        // column already past the new length, so the next byte closes the row
        wait_drained();
        write_reg(CFG_ROW_BYTES, 16'd3);
        end_writes();
        send_byte(pick_data());
        send_row(FLT_PAETH);
        send_row(FLT_AVG);
        // grow back only as far as the first row was written
        wait_drained();
        write_reg(CFG_ROW_BYTES, 16'd6);
        end_writes();
        send_row(FLT_UP);
        // row count already beyond the new image height, this row ends the image
        wait_drained();
        write_reg(CFG_IMAGE_ROWS, 16'd2);
        end_writes();
        send_row(FLT_SUB);
    endtask

    // widest pixels and the out-of-range register values
    task automatic test_register_extremes();
        gaps_on = 1'b0;
        set_geometry(16'd8, 16'd40, 16'd2);
        send_row(FLT_AVG);
        send_row(FLT_PAETH);
        set_geometry(16'd15, 16'd24, 16'd0);
        send_row(FLT_SUB);
        set_geometry(16'd0, 16'd0, 16'd3);
        send_row(FLT_PAETH);
        send_row(FLT_UP);
        send_row(FLT_AVG);
        gaps_on = 1'b1;
    endtask

    // output held off for a long stretch while the stream keeps coming
    task automatic test_input_backpressure();
        set_geometry(16'd3, 16'd16, 16'd4);
        gaps_on         = 1'b0;
        out_hold_cycles = 300;
        repeat (4) send_row(pick_filter());
        gaps_on = 1'b1;
    endtask

    // whole images of random geometry, with the odd register change between rows
    task automatic test_random_images();
        int                    target;
        logic [CFG_DATA_W-1:0] bpp_w;
        logic [CFG_DATA_W-1:0] rb_w;
        logic [CFG_DATA_W-1:0] rows_w;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            bpp_w   = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 15)) :
                                                    16'($urandom_range(1, 8));
            case ($urandom_range(0, 19))
                0:       rb_w = 16'($urandom_range(65, 400));
                1, 2, 3,
                4, 5:    rb_w = 16'($urandom_range(17, 64));
                default: rb_w = 16'($urandom_range(1, 16));
            endcase
            rows_w = 16'($urandom_range(0, 6));
            // unused upper bits of the narrow registers must be ignored
            if ($urandom_range(0, 3) == 0) begin
                bpp_w[15:4]  = 12'($urandom);
                rb_w[15:14]  = 2'($urandom);
            end
            set_geometry(bpp_w, rb_w, rows_w);
            do begin
                if (row_pos != 0 && $urandom_range(0, 7) == 0) begin
                    wait_drained();
                    write_reg(CFG_BYTES_PER_PIXEL, 16'($urandom_range(0, 15)));
                    if ($urandom_range(0, 1) == 0) begin
                        write_reg(CFG_IMAGE_ROWS, 16'($urandom_range(0, 6)));
                    end
                    end_writes();
                end
                send_row(pick_filter());
            end while (row_pos != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall runs, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------
    initial begin : out_stall_gen
        int n;
        @(posedge i_clk);
        forever begin
            n = 0;
            if (out_hold_cycles != 0) begin
                n               = out_hold_cycles;
                out_hold_cycles = 0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                n = idle_len();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // result checking: each output transfer against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none got pixel_byte %0h",
                         $time, o_pixel_byte);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_byte", want.pixel_byte, o_pixel_byte);
                check_field("row_end", want.row_end, o_row_end);
                check_field("image_end", want.image_end, o_image_end);
                check_field("bad_filter", want.bad_filter, o_bad_filter);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_BYTES_PER_PIXEL;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_stream_byte = 8'h00;
        i_out_stall   = 1'b0;
        clear_unfilter_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_after_reset();
        test_every_filter();
        test_mid_stream_writes();
        test_register_extremes();
        test_input_backpressure();
        test_random_images();

        wait_drained();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- png_scanline_unfilter_unit.f -----
hw/rtl/pngunf_pkg.sv
hw/rtl/pngunf_line_buf.sv
hw/rtl/pngunf_out_buf.sv
hw/rtl/png_scanline_unfilter_unit.sv
dv/tb_png_scanline_unfilter_unit.sv
